@@ src/fre_pkg.sv @@
// shared constants and types for the escaped frame receiver
package fre_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 64;
    localparam int Q_DEPTH = 2;
    localparam int PLEN_W = 6;

    localparam logic [7:0] START_BYTE = 8'hFD;
    localparam logic [7:0] ESC_BYTE = 8'hFC;
    localparam logic [7:0] ESC_MARK = 8'h80;
    localparam logic [15:0] CRC_POLY = 16'h1002;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_OK      = 2'd0,
        KIND_CRC_ERR = 2'd1,
        KIND_LEN_ERR = 2'd2
    } kind_t;

    // one finished frame, handed from the front to the back
    typedef struct packed {
        kind_t              kind;
        logic [31:0]        target;
        logic [31:0]        sender;
        logic [7:0]         control;
        logic [PLEN_W-1:0]  plen;
    } job_t;

endpackage

@@ src/fre_front.sv @@
// byte front end: unescaping, header parsing, crc and payload writes
module fre_front import fre_pkg::*; #(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
    parameter int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          q_full,
    output logic          push,
    output job_t          push_job,
    input  logic          done,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data
);

    localparam int LEN_LIMIT = (BUFFER_BYTES < 64) ? BUFFER_BYTES : 64;
    localparam int LEN_W = 7;
    localparam logic [3:0] POS_PAYLOAD = 4'd15;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        logic        top;
        c = c_in;
        for (int i = 0; i < 8; i++) begin
            top = c[15];
            c = {c[14:0], b[7-i]};
            if (top) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_START = crc_byte(CRC_INIT, START_BYTE);

    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [3:0]       hp_reg, hp_next;
    logic             busy_reg, busy_next;
    logic [31:0]      target_reg, target_next;
    logic [31:0]      sender_reg, sender_next;
    logic [7:0]       control_reg, control_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;

    logic             accept;
    logic [7:0]       bb;
    logic [15:0]      crc_step;
    logic [LEN_W-1:0] count_inc;

    assign s_tready  = !busy_reg && !q_full;
    assign accept    = s_tvalid && s_tready;
    assign bb        = esc_reg ? (s_tdata | ESC_MARK) : s_tdata;
    assign crc_step  = crc_byte(crc_reg, bb);
    assign count_inc = count_reg + LEN_W'(1);
    assign wr_addr   = AW'(count_reg);
    assign wr_data   = bb;

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        hp_next       = hp_reg;
        busy_next     = busy_reg;
        target_next   = target_reg;
        sender_next   = sender_reg;
        control_next  = control_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        push          = 1'b0;
        wr_en         = 1'b0;
        push_job.kind    = KIND_OK;
        push_job.target  = target_reg;
        push_job.sender  = sender_reg;
        push_job.control = control_reg;
        push_job.plen    = '0;
        if (accept) begin
            if (s_tdata == ESC_BYTE && !esc_reg) begin
                esc_next = 1'b1;
            end else if (s_tdata == START_BYTE) begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                hp_next       = '0;
                target_next   = '0;
                sender_next   = '0;
                control_next  = '0;
                len_next      = '0;
                count_next    = '0;
                crc_next      = CRC_START;
            end else if (in_frame_reg) begin
                esc_next = 1'b0;
                crc_next = crc_step;
                if (hp_reg < 4'd4) begin
                    target_next = {target_reg[23:0], bb};
                    hp_next     = hp_reg + 4'd1;
                end else if (hp_reg == 4'd4) begin
                    control_next = bb;
                    hp_next      = hp_reg + 4'd1;
                end else if (control_reg[3] && hp_reg < 4'd9) begin
                    sender_next = {sender_reg[23:0], bb};
                    hp_next     = hp_reg + 4'd1;
                end else if (hp_reg != POS_PAYLOAD) begin
                    hp_next  = POS_PAYLOAD;
                    len_next = bb[LEN_W-1:0];
                    if (bb < 8'd2 || bb > 8'(LEN_LIMIT)) begin
                        in_frame_next = 1'b0;
                        push          = 1'b1;
                        push_job.kind = KIND_LEN_ERR;
                    end
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_inc;
                    if (count_inc >= len_reg) begin
                        in_frame_next = 1'b0;
                        push          = 1'b1;
                        push_job.plen = PLEN_W'(len_reg - LEN_W'(2));
                        if (crc_step != 16'd0) begin
                            push_job.kind = KIND_CRC_ERR;
                        end else if (len_reg != LEN_W'(2)) begin
                            busy_next = 1'b1;
                        end
                    end
                end
            end
        end
        if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            hp_reg       <= '0;
            busy_reg     <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            hp_reg       <= hp_next;
            busy_reg     <= busy_next;
        end
        target_reg  <= target_next;
        sender_reg  <= sender_next;
        control_reg <= control_next;
        len_reg     <= len_next;
        count_reg   <= count_next;
        crc_reg     <= crc_next;
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("frame pushed into a full queue");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> busy_reg)
        else $error("buffer release without an outstanding frame");

endmodule

@@ src/fre_queue.sv @@
// short queue of finished frame descriptors between front and back
module fre_queue import fre_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    job_t           entries [Q_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]   count_reg;
    logic           do_push, do_pop;

    assign full    = count_reg == (QPW+1)'(Q_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (QPW+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (QPW+1)'(1);
            end
        end
        if (do_push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/fre_back.sv @@
// back end: payload buffer and result sequencer
module fre_back import fre_pkg::*; #(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
    parameter int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    output logic          pop,
    input  job_t          head,
    output logic          done,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } state_t;

    logic [7:0]        mem [BUFFER_BYTES];
    logic [7:0]        rd_data_reg;
    state_t            state_reg;
    job_t              job_reg;
    logic [PLEN_W-1:0] idx_reg;
    logic              m_tvalid_reg;
    job_t              out_job_reg;
    logic [7:0]        out_data_reg;
    logic [PLEN_W-1:0] out_idx_reg;
    logic              out_last_reg;

    logic simple, head_simple, last_now, out_free, out_load;

    assign simple      = (job_reg.kind != KIND_OK) || (job_reg.plen == '0);
    assign head_simple = (head.kind != KIND_OK) || (head.plen == '0);
    assign last_now    = simple || (PLEN_W'(idx_reg + PLEN_W'(1)) == job_reg.plen);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign out_load    = (state_reg == ST_SEND) && out_free;
    assign pop         = (state_reg == ST_IDLE) && !q_empty;
    assign done        = (state_reg == ST_SEND) && out_free && last_now && !simple;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == ST_FETCH) begin
            rd_data_reg <= mem[AW'(idx_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= head;
                        idx_reg   <= '0;
                        state_reg <= head_simple ? ST_SEND : ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_SEND;
                end
                ST_SEND: begin
                    if (out_free) begin
                        out_job_reg  <= job_reg;
                        out_data_reg <= simple ? 8'd0 : rd_data_reg;
                        out_idx_reg  <= simple ? '0 : idx_reg;
                        out_last_reg <= last_now;
                        if (last_now) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + PLEN_W'(1);
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_job_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_idx_reg, out_data_reg, out_job_reg.plen,
                       out_job_reg.control, out_job_reg.sender, out_job_reg.target};

    a_fetch_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> !simple)
        else $error("buffer read for a frame without payload");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && !simple) |-> (idx_reg < job_reg.plen))
        else $error("payload index beyond frame length");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after final payload transfer");

endmodule

@@ src/escaped_frame_receiver_crc16.sv @@
// top level: escaped byte frame receiver with crc-16 check
// input: one byte per cycle while the queue has room and no payload frame is being emitted
// a result passes the queue, the sequencer job register and the output register
// each payload result takes a buffer read, then an output register load
// input stalls from a payload frame's final byte until its last result is registered
// reset: synchronous active low, clears control state; the payload buffer is not cleared
module escaped_frame_receiver_crc16 import fre_pkg::*; #(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // dest_address, sender_address, control_byte, payload_length, data_byte, byte_index
    output logic [95:0] m_tdata,
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    logic          push, pop, q_full, q_empty, done, wr_en;
    job_t          push_job, head;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    fre_front #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .AW(AW)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .q_full(q_full),
        .push(push),
        .push_job(push_job),
        .done(done),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    fre_queue u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_job(push_job),
        .pop(pop),
        .head(head),
        .full(q_full),
        .empty(q_empty)
    );

    fre_back #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .AW(AW)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .pop(pop),
        .head(head),
        .done(done),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

endmodule
